// ===== hdl/sirt_pkg.sv =====
// sirt_pkg: widths, character codes, register indexes and the reciprocal table
// for the signed integer to radix text block
// no dependencies
package sirt_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_RADIX   = 16;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int STACK_AW    = $clog2(VALUE_BITS);
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int REM_W       = RADIX_W + 1;

    // quotient by reciprocal: q ~ (m * floor(2^S / r)) >> S, off by at most one
    localparam int RECIP_SHIFT = VALUE_BITS + 4;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int LO_W        = RECIP_W / 2;
    localparam int HI_W        = RECIP_W - LO_W;
    localparam int ACC_W       = VALUE_BITS + RECIP_W;

    localparam logic [RECIP_SHIFT:0] RECIP_ONE = (RECIP_SHIFT + 1)'(1) << RECIP_SHIFT;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef logic [VALUE_BITS-1:0] mag_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] r);
        logic [RECIP_W-1:0] res;
        case (r)
            RADIX_W'(2):  res = RECIP_W'(RECIP_ONE / 2);
            RADIX_W'(3):  res = RECIP_W'(RECIP_ONE / 3);
            RADIX_W'(4):  res = RECIP_W'(RECIP_ONE / 4);
            RADIX_W'(5):  res = RECIP_W'(RECIP_ONE / 5);
            RADIX_W'(6):  res = RECIP_W'(RECIP_ONE / 6);
            RADIX_W'(7):  res = RECIP_W'(RECIP_ONE / 7);
            RADIX_W'(8):  res = RECIP_W'(RECIP_ONE / 8);
            RADIX_W'(9):  res = RECIP_W'(RECIP_ONE / 9);
            RADIX_W'(10): res = RECIP_W'(RECIP_ONE / 10);
            RADIX_W'(11): res = RECIP_W'(RECIP_ONE / 11);
            RADIX_W'(12): res = RECIP_W'(RECIP_ONE / 12);
            RADIX_W'(13): res = RECIP_W'(RECIP_ONE / 13);
            RADIX_W'(14): res = RECIP_W'(RECIP_ONE / 14);
            RADIX_W'(15): res = RECIP_W'(RECIP_ONE / 15);
            RADIX_W'(16): res = RECIP_W'(RECIP_ONE / 16);
            default:      res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/signed_integer_to_radix_text_top.sv =====
// signed_integer_to_radix_text_top: converts a signed number into text beats
// in a configured radix with a configured symbol table
// depends on sirt_pkg
//
// One value is taken at a time. Its magnitude is divided by the radix once per
// digit, each division made of two half-width reciprocal multiplies and a
// correction step, and the digits go into a 32-entry stack memory. The text
// then leaves most significant digit first, led by '-' for a negative value,
// each beat read from the stack and then offered, held while the output is
// stalled; last marks the final beat. With an invalid base (radix below two,
// or a used symbol that is '+', '-', zero or repeated) the value is taken and
// produces no beats. A radix above 16 acts as 16. Registers are to be written
// only while idle, by the user; the block itself does not enforce this.
module signed_integer_to_radix_text_top
    import sirt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SYM_W-1:0]     symbol,
    output logic                 last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_FIX    = 3'd4;
    localparam logic [2:0] ST_SIGN   = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [RADIX_W-1:0]       radix_reg;
    logic [CFG_W-1:0]         symbols_low_reg;
    logic [CFG_W-1:0]         symbols_high_reg;

    logic                     base_ok_reg, base_ok_next;
    logic [RADIX_W-1:0]       r_reg, r_next;
    logic [RECIP_W-1:0]       recip_reg;

    logic [2:0]               state_reg, state_next;
    mag_t                     mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [VALUE_BITS+LO_W-1:0] prod_lo_reg;
    logic [ACC_W-1:0]         acc_reg;

    logic [DIGIT_W-1:0]       stack_mem [VALUE_BITS];
    logic [DIGIT_W-1:0]       rd_data_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]         symbol_reg, symbol_next;
    logic                     last_reg, last_next;

    logic [2*CFG_W-1:0]       sym_vec;
    logic                     in_beat;
    logic                     out_free;

    logic [VALUE_BITS+LO_W-1:0] lo_prod;
    logic [VALUE_BITS+HI_W-1:0] hi_prod;
    mag_t                     q0;
    mag_t                     q_fix;
    logic [2*REM_W-1:0]       qr_lo;
    logic [REM_W-1:0]         rem0;
    logic                     adj;
    logic [DIGIT_W-1:0]       digit;
    logic                     push;

    assign sym_vec  = {symbols_high_reg, symbols_low_reg};
    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIX:        radix_reg        <= cfg_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // base check: radix at least two, no used symbol '+', '-' or zero, and every pair of used symbols distinct
    always_comb
    begin
        logic [SYM_W-1:0] si;
        r_next = (radix_reg > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_reg;
        base_ok_next = (r_next >= RADIX_W'(2));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            si = sym_vec[i*SYM_W +: SYM_W];
            if (RADIX_W'(i) < r_next)
            begin
                if (si == CHAR_PLUS || si == CHAR_MINUS || si == CHAR_NUL)
                    base_ok_next = 1'b0;
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < r_next && sym_vec[j*SYM_W +: SYM_W] == si)
                        base_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_ok_reg <= 1'b0;
            r_reg       <= '0;
            recip_reg   <= '0;
        end
        else
        begin
            base_ok_reg <= base_ok_next;
            r_reg       <= r_next;
            recip_reg   <= recip_of(r_next);
        end
    end

    // digit arithmetic
    always_comb
    begin
        lo_prod = {LO_W'(0), mag_reg} * {VALUE_BITS'(0), recip_reg[LO_W-1:0]};
        hi_prod = {HI_W'(0), mag_reg} * {VALUE_BITS'(0), recip_reg[RECIP_W-1:LO_W]};
        q0      = acc_reg[ACC_W-1 -: VALUE_BITS];
        // true remainder is below twice the radix, so the low bits suffice
        qr_lo   = {REM_W'(0), q0[REM_W-1:0]} * {{(REM_W+1){1'b0}}, r_reg};
        rem0    = mag_reg[REM_W-1:0] - qr_lo[REM_W-1:0];
        adj     = (rem0 >= {1'b0, r_reg});
        digit   = adj ? DIGIT_W'(rem0 - {1'b0, r_reg}) : rem0[DIGIT_W-1:0];
        q_fix   = q0 + VALUE_BITS'(adj);
        push    = (state_reg == ST_FIX) && (count_reg < CNT_W'(VALUE_BITS));
    end

    // digit stack: all pushes of an item finish before its first pop
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[count_reg[STACK_AW-1:0]] <= digit;
        if (state_reg == ST_READ)
            rd_data_reg <= stack_mem[count_reg[STACK_AW-1:0] - STACK_AW'(1)];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL_LO)
            prod_lo_reg <= lo_prod;
        if (state_reg == ST_MUL_HI)
            acc_reg <= ACC_W'(prod_lo_reg) + {hi_prod, LO_W'(0)};
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    neg_next   = value[VALUE_BITS-1];
                    mag_next   = value[VALUE_BITS-1] ? mag_t'(-value) : mag_t'(value);
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
                state_next = base_ok_reg ? ST_MUL_LO : ST_IDLE;
            ST_MUL_LO:
                state_next = ST_MUL_HI;
            ST_MUL_HI:
                state_next = ST_FIX;
            ST_FIX:
            begin
                mag_next = q_fix;
                if (push)
                    count_next = count_reg + CNT_W'(1);
                if (q_fix == '0)
                    state_next = neg_reg ? ST_SIGN : ST_READ;
                else
                    state_next = ST_MUL_LO;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                count_next = count_reg - CNT_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = sym_vec[{rd_data_reg, 3'b000} +: SYM_W];
                    last_next      = (count_reg == '0);
                    state_next     = (count_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

endmodule

// ===== hdl/sirt_checker.sv =====
// sirt_checker: port-level checks on the text output of the block
// depends on sirt_pkg; bound to signed_integer_to_radix_text_top
module sirt_checker
    import sirt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SYM_W-1:0] symbol,
    input logic             last
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last))
    else $error("output beat changed while stalled");

    // a valid base never maps a digit to a forbidden byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol != CHAR_PLUS && symbol != CHAR_NUL)
    else $error("forbidden byte on output");

    // the sign always has digits after it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && symbol == CHAR_MINUS |-> !last)
    else $error("sign beat flagged as last");

    // no two sign beats in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && symbol == CHAR_MINUS |=> !(out_valid && symbol == CHAR_MINUS))
    else $error("sign beat repeated");

endmodule

bind signed_integer_to_radix_text_top sirt_checker u_sirt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last)
);

// ===== test/tb_signed_integer_to_radix_text_top.sv =====
// tb_signed_integer_to_radix_text_top: self-checking bench for the radix text converter
// a scoreboard class predicts the text beats of each accepted value from its own copy of the base
// depends on sirt_pkg and signed_integer_to_radix_text_top
module tb_signed_integer_to_radix_text_top;
    import sirt_pkg::*;

    typedef logic signed [VALUE_BITS-1:0] num_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } text_beat_t;

    typedef enum int unsigned {
        SPOIL_RADIX,
        SPOIL_PLUS,
        SPOIL_MINUS,
        SPOIL_NUL,
        SPOIL_REPEAT
    } spoil_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam num_t MOST_NEG      = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam num_t MOST_POS      = ~MOST_NEG;
    localparam int   RANDOM_ITEMS  = 350;
    localparam int   SETTLE_CYCLES = 200;
    localparam int   CYCLE_LIMIT   = 1000000;

    // ascii digit tables, digit 0 in the lowest byte
    localparam logic [CFG_W-1:0] DEC_LOW    = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] HEX_HIGH   = 64'h4645_4443_4241_3938;
    localparam logic [CFG_W-1:0] LHEX_HIGH  = 64'h6665_6463_6261_3938;

    class radix_text_scoreboard;
        logic [RADIX_W-1:0] radix_reg;
        logic [CFG_W-1:0]   sym_lo;
        logic [CFG_W-1:0]   sym_hi;
        text_beat_t         expected_text[$];
        int                 errors;
        int                 beats_checked;

        function new();
            radix_reg     = '0;
            sym_lo        = '0;
            sym_hi        = '0;
            errors        = 0;
            beats_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RADIX:        radix_reg = data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_lo    = data;
                REG_SYMBOLS_HIGH: sym_hi    = data;
                default:          ;
            endcase
        endfunction

        function logic [SYM_W-1:0] digit_symbol(int unsigned d);
            if (d < 8)
                return sym_lo[d*SYM_W +: SYM_W];
            else
                return sym_hi[(d-8)*SYM_W +: SYM_W];
        endfunction

        // zero means the base cannot be used
        function int unsigned usable_radix();
            int unsigned      r;
            logic [SYM_W-1:0] c;
            r = radix_reg;
            if (r > MAX_RADIX)
                r = MAX_RADIX;
            if (r < 2)
                return 0;
            for (int unsigned i = 0; i < r; i++)
            begin
                c = digit_symbol(i);
                if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_NUL)
                    return 0;
                for (int unsigned j = i + 1; j < r; j++)
                    if (digit_symbol(j) == c)
                        return 0;
            end
            return r;
        endfunction

        function int note_value(num_t v);
            int unsigned        r;
            mag_t               mag;
            logic [DIGIT_W-1:0] digits[$];
            text_beat_t         b;
            int                 n;
            n = 0;
            r = usable_radix();
            if (r == 0)
                return 0;
            mag = v[VALUE_BITS-1] ? ~mag_t'(v) + 1'b1 : mag_t'(v);
            do
            begin
                digits.push_back(DIGIT_W'(mag % r));
                mag = mag / r;
            end
            while (mag != 0);
            if (v[VALUE_BITS-1])
            begin
                b.symbol = CHAR_MINUS;
                b.last   = 1'b0;
                expected_text.push_back(b);
                n++;
            end
            for (int k = digits.size() - 1; k >= 0; k--)
            begin
                b.symbol = digit_symbol(digits[k]);
                b.last   = (k == 0);
                expected_text.push_back(b);
                n++;
            end
            return n;
        endfunction

        function void check_beat(logic [SYM_W-1:0] sym, logic lst);
            text_beat_t want;
            beats_checked++;
            if (expected_text.size() == 0)
            begin
                $error("beat with nothing expected: symbol %h last %b", sym, lst);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (sym !== want.symbol)
            begin
                $error("symbol mismatch: expected %h, actual %h", want.symbol, sym);
                errors++;
            end
            if (lst !== want.last)
            begin
                $error("last mismatch: expected %b, actual %b", want.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction

        function void report_leftover();
            if (expected_text.size() != 0)
            begin
                $error("%0d expected beats never arrived", expected_text.size());
                errors++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RADIX;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    num_t                 value     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SYM_W-1:0]     symbol;
    logic                 last;

    radix_text_scoreboard sb;
    bit                   no_idle = 1'b0;
    int                   stall_left = 0;
    int                   cycle_count = 0;
    int                   values_sent = 0;
    int                   texted_values = 0;
    int                   bases_loaded = 0;

    signed_integer_to_radix_text_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // receiving side: check each taken beat, then maybe hold ready low for a while
    always @(posedge clk)
    begin : text_sink
        int unsigned hold;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_beat(symbol, last);
                hold = no_idle ? 0 : $urandom_range(0, 3);
                stall_left = hold;
                if (hold != 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (stall_left > 1)
                    stall_left--;
                else
                begin
                    stall_left = 0;
                    out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic load_base(logic [CFG_W-1:0] radix_word, logic [CFG_W-1:0] lo,
                             logic [CFG_W-1:0] hi, bit poke_unused);
        logic [CFG_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= REG_RADIX;
        cfg_data  <= radix_word;
        sb.set_reg(REG_RADIX, radix_word);
        @(posedge clk);
        cfg_index <= REG_SYMBOLS_LOW;
        cfg_data  <= lo;
        sb.set_reg(REG_SYMBOLS_LOW, lo);
        @(posedge clk);
        cfg_index <= REG_SYMBOLS_HIGH;
        cfg_data  <= hi;
        sb.set_reg(REG_SYMBOLS_HIGH, hi);
        @(posedge clk);
        if (poke_unused)
        begin
            // index past the register file, must change nothing
            cfg_index <= REG_UNUSED;
            cfg_data  <= junk;
            sb.set_reg(REG_UNUSED, junk);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        bases_loaded++;
    endtask

    task automatic send_value(num_t v);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        values_sent++;
        if (sb.note_value(v) > 0)
            texted_values++;
    endtask

    task automatic pause_until_empty();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // an invalid base gives no beats, so also let the block go back to idle
    task automatic drain();
        pause_until_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_base(logic [CFG_W-1:0] radix_word, logic [CFG_W-1:0] lo,
                              logic [CFG_W-1:0] hi, bit poke_unused);
        drain();
        load_base(radix_word, lo, hi, poke_unused);
    endtask

    function automatic void make_base(bit spoil, output logic [CFG_W-1:0] radix_word,
                                      output logic [CFG_W-1:0] lo,
                                      output logic [CFG_W-1:0] hi);
        logic [SYM_W-1:0] pool[16];
        bit               used[256];
        logic [SYM_W-1:0] c;
        int unsigned      r;
        int unsigned      eff;
        int unsigned      i;
        int unsigned      j;
        for (i = 0; i < 256; i++)
            used[i] = 1'b0;
        for (i = 0; i < 16; i++)
        begin
            do
                c = SYM_W'($urandom_range(1, 255));
            while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
            used[c] = 1'b1;
            pool[i] = c;
        end
        r   = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(2, 16);
        eff = (r > MAX_RADIX) ? MAX_RADIX : r;
        // bytes past the radix are don't-care, so let them hold anything at all
        for (i = eff; i < 16; i++)
            if ($urandom_range(0, 1) != 0)
                pool[i] = SYM_W'($urandom);
        if (spoil)
        begin
            i = $urandom_range(0, eff - 1);
            case (spoil_t'($urandom_range(SPOIL_RADIX, SPOIL_REPEAT)))
                SPOIL_RADIX: r       = $urandom_range(0, 1);
                SPOIL_PLUS:  pool[i] = CHAR_PLUS;
                SPOIL_MINUS: pool[i] = CHAR_MINUS;
                SPOIL_NUL:   pool[i] = CHAR_NUL;
                default:
                begin
                    j       = (i + 1 + $urandom_range(0, eff - 2)) % eff;
                    pool[j] = pool[i];
                end
            endcase
        end
        for (i = 0; i < 8; i++)
        begin
            lo[i*SYM_W +: SYM_W] = pool[i];
            hi[i*SYM_W +: SYM_W] = pool[i+8];
        end
        radix_word              = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = RADIX_W'(r);
    endfunction

    function automatic num_t random_value();
        case ($urandom_range(0, 3))
            0, 1:    return num_t'($urandom);
            2:       return num_t'($urandom_range(0, 40)) - 20;
            default: return ($urandom_range(0, 1) ? MOST_NEG : MOST_POS)
                            ^ num_t'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] radix_word;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        bit               spoil;
        int               phase;
        int               count;
        int               prior_texted;
        int               random_texted;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: radix zero, nothing comes out
        send_value('0);
        send_value(-1);

        apply_base(64'd10, DEC_LOW, HEX_HIGH, 1'b0);
        send_value('0);
        send_value(1);
        send_value(-1);
        send_value(MOST_POS);
        send_value(MOST_NEG);
        send_value(-10);

        apply_base(64'd2, DEC_LOW, HEX_HIGH, 1'b0);
        send_value(MOST_NEG);
        send_value(MOST_POS);
        send_value(-1);

        apply_base(64'd16, DEC_LOW, LHEX_HIGH, 1'b0);
        send_value(MOST_NEG);
        send_value(MOST_POS);
        send_value(32'hdead_beef);

        // radix above sixteen saturates, and the stray index write is ignored
        apply_base(64'd31, DEC_LOW, HEX_HIGH, 1'b1);
        send_value(32'h0123_4567);

        apply_base(64'd1, DEC_LOW, HEX_HIGH, 1'b0);
        send_value(5);

        // plus sign among the used symbols
        apply_base(64'd10, {DEC_LOW[63:32], CHAR_PLUS, DEC_LOW[23:0]}, HEX_HIGH, 1'b0);
        send_value(7);

        // minus sign on digit nine
        apply_base(64'd10, DEC_LOW, {HEX_HIGH[63:16], CHAR_MINUS, HEX_HIGH[7:0]}, 1'b0);
        send_value(7);

        // zero byte on the top digit
        apply_base(64'd16, DEC_LOW, {CHAR_NUL, HEX_HIGH[55:0]}, 1'b0);
        send_value(7);

        // digit eleven repeats digit zero
        apply_base(64'd12, DEC_LOW, {HEX_HIGH[63:32], DEC_LOW[7:0], HEX_HIGH[23:0]}, 1'b0);
        send_value(7);

        // forbidden bytes sit only past the radix
        apply_base(64'd3, 64'h2D00_2B00_2D63_6261, 64'h0, 1'b0);
        send_value(MOST_NEG);
        send_value(100);

        random_texted = 0;
        phase         = 0;
        while (random_texted < RANDOM_ITEMS)
        begin
            phase++;
            spoil = ($urandom_range(0, 5) == 0);
            make_base(spoil, radix_word, lo, hi);
            apply_base(radix_word, lo, hi, $urandom_range(0, 3) == 0);
            no_idle = (phase % 5 == 2);
            count   = spoil ? 4 : $urandom_range(30, 60);
            for (int k = 0; k < count && random_texted < RANDOM_ITEMS; k++)
            begin
                prior_texted = texted_values;
                send_value(random_value());
                if (texted_values != prior_texted)
                    random_texted++;
                if (phase == 2 && k == 15)
                    pause_until_empty();
            end
        end
        no_idle = 1'b0;

        drain();
        sb.report_leftover();
        $display("converted %0d values under %0d base settings", values_sent, bases_loaded);
        $display("%0d values gave text, %0d beats compared", texted_values, sb.beats_checked);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sirt_pkg.sv
hdl/signed_integer_to_radix_text_top.sv
hdl/sirt_checker.sv
test/tb_signed_integer_to_radix_text_top.sv
